// ===== sv/kec_pkg.sv =====
// Shared types and constants for the keypad entry collector.
package kec_pkg;

	localparam int unsigned ENTRY_CAPACITY_DEF   = 16;
	localparam bit          END_KEY_REQUIRED_DEF = 1'b0;

	localparam int unsigned KEY_W     = 6;
	localparam int unsigned MASK_W    = 64;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned CFG_IDX_W = 4;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MASK   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_MASK    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_MASK   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MASK     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_MASK = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 4'd7;

	typedef enum logic [1:0] {
		FUNC_KEY     = 2'd0,
		FUNC_TICK    = 2'd1,
		FUNC_ENABLE  = 2'd2,
		FUNC_DISABLE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_PROGRESS = 2'd0,
		KIND_SUBMIT   = 2'd1,
		KIND_TIMEOUT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [MASK_W-1:0] start_mask;
		logic [MASK_W-1:0] back_mask;
		logic [MASK_W-1:0] clear_mask;
		logic [MASK_W-1:0] end_mask;
		logic [MASK_W-1:0] allowed_mask;
		logic [LEN_W-1:0]  min_length;
		logic [LEN_W-1:0]  max_length;
		logic [TICK_W-1:0] timeout_ms;
	} cfg_t;

endpackage

// ===== sv/keypad_entry_collector_top.sv =====
// Keypad entry collector top level: item decode, entry memory and result sequencer.
//
// Input channel (in_valid/in_ready, func, key_code): one word per event - key
// press, millisecond tick, enable or disable. Output channel (out_valid/out_ready)
// carries result words: progress updates, submitted or timed out entries streamed
// oldest key first, then usually a progress word; last marks the final word of
// the results of one input word. Config channel (cfg_valid/cfg_ready) writes
// one register per word; cfg_ready is always high. User must write only while idle (not enforced).
//
// Keys live in a single-port-write, registered-read memory of ENTRY_CAPACITY
// entries. An input word is decoded in the cycle it is accepted; state updates
// and the key write happen at that edge. Results then follow: first a registered
// memory read, then one word per cycle while the output slot is free. An
// input word that makes no result words leaves the sequencer idle. in_ready is
// high only while the sequencer is idle, but the last result word may still sit
// in the output register waiting to be taken. A stalled receiver freezes the
// sequencer with the memory read data held. Reset clears counts, start key, idle
// counter and config, and enables the block; the entry memory needs no clearing
// pass.
module keypad_entry_collector_top #(
	parameter int unsigned ENTRY_CAPACITY   = kec_pkg::ENTRY_CAPACITY_DEF,
	parameter bit          END_KEY_REQUIRED = kec_pkg::END_KEY_REQUIRED_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kec_pkg::MASK_W-1:0]    cfg_data,
	// input word channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [kec_pkg::KEY_W-1:0]     key_code,
	// result word channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [kec_pkg::KEY_W-1:0]     key_value,
	output logic [kec_pkg::POS_W-1:0]     position,
	output logic [kec_pkg::LEN_W-1:0]     entry_length,
	output logic [kec_pkg::KEY_W-1:0]     start_code,
	output logic                          start_valid,
	output logic [kec_pkg::KEY_W-1:0]     end_code,
	output logic                          end_valid,
	output logic                          last
);

	// count must hold ENTRY_CAPACITY itself; address only indexes entries
	localparam int unsigned CW    = $clog2(ENTRY_CAPACITY + 1);
	localparam int unsigned AW    = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
	localparam int unsigned CMP_W = (CW > kec_pkg::LEN_W) ? CW : kec_pkg::LEN_W;
	localparam int unsigned KW    = kec_pkg::KEY_W;
	localparam int unsigned TW    = kec_pkg::TICK_W;

	typedef enum logic [2:0] {
		S_IDLE,   // waiting for an input word
		S_SRD,    // first stream read in flight
		S_SOUT,   // emit stream words, one per cycle while the output slot is free
		S_PRD,    // progress read in flight
		S_POUT    // emit the progress word
	} state_t;

	kec_pkg::cfg_t cfg;

	kec_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- state
	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [KW-1:0]     start_code_q;
	logic              start_flag_q;
	logic              active_q;
	logic [TW-1:0]     idle_q;

	// stream context captured at acceptance (pre-discard view of the entry)
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     strm_len_q;
	kec_pkg::kind_t    strm_kind_q;
	logic [KW-1:0]     strm_sc_q;
	logic              strm_sv_q;
	logic [KW-1:0]     strm_ec_q;
	logic              strm_ev_q;
	logic              prog_q;

	// output register
	logic              out_valid_q;
	kec_pkg::kind_t    kind_q;
	logic [KW-1:0]     key_value_q;
	logic [kec_pkg::POS_W-1:0] position_q;
	logic [kec_pkg::LEN_W-1:0] length_q;
	logic [KW-1:0]     start_code_out_q;
	logic              start_valid_q;
	logic [KW-1:0]     end_code_q;
	logic              end_valid_q;
	logic              last_q;

	// entry memory
	logic [KW-1:0]     mem [ENTRY_CAPACITY];
	logic [KW-1:0]     mem_rdata_q;
	logic              mem_we;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	// ---------------------------------------------------------------- decode
	logic              in_accept;
	logic [CMP_W-1:0]  cnt_x;
	logic [CMP_W-1:0]  min_x;
	logic [CMP_W-1:0]  max_x;
	logic [CMP_W-1:0]  cap_x;
	logic [CMP_W-1:0]  limit;
	logic [CW-1:0]     cnt_inc;
	logic [CW-1:0]     cnt_m1;
	logic              had;

	logic [CW-1:0]     d_count;
	logic [KW-1:0]     d_scode;
	logic              d_sflag;
	logic              d_active;
	logic [TW-1:0]     d_idle;
	logic              d_store;
	logic              d_strm;
	logic [CW-1:0]     d_slen;
	kec_pkg::kind_t    d_kind;
	logic [KW-1:0]     d_ec;
	logic              d_ev;
	logic              d_prog;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid & in_ready;

	assign cnt_x   = CMP_W'(count_q);
	assign min_x   = CMP_W'(cfg.min_length);
	assign max_x   = CMP_W'(cfg.max_length);
	assign cap_x   = CMP_W'(ENTRY_CAPACITY);
	// zero or oversized max_length means full capacity
	assign limit   = ((cfg.max_length == '0) || (max_x > cap_x)) ? cap_x : max_x;
	assign cnt_inc = count_q + 1'b1;
	assign cnt_m1  = count_q - 1'b1;
	assign had     = (count_q != '0) || start_flag_q;

	always_comb begin
		d_count  = count_q;
		d_scode  = start_code_q;
		d_sflag  = start_flag_q;
		d_active = active_q;
		d_idle   = idle_q;
		d_store  = 1'b0;
		d_strm   = 1'b0;
		d_slen   = count_q;
		d_kind   = kec_pkg::KIND_SUBMIT;
		d_ec     = '0;
		d_ev     = 1'b0;
		d_prog   = 1'b0;
		case (func)
			kec_pkg::FUNC_KEY: begin
				if (active_q) begin
					d_idle = '0;
					if ((cfg.start_mask != '0) && !start_flag_q) begin
						// waiting for a start key; anything else is swallowed
						if (cfg.start_mask[key_code]) begin
							d_scode = key_code;
							d_sflag = 1'b1;
							d_prog  = 1'b1;
						end
					end else if (cfg.back_mask[key_code]) begin
						if (count_q != '0) begin
							d_count = cnt_m1;
							d_prog  = 1'b1;
						end
					end else if (cfg.clear_mask[key_code]) begin
						d_count = '0;
						d_scode = '0;
						d_sflag = 1'b0;
						d_prog  = had;
					end else if (cfg.end_mask[key_code]) begin
						if ((cfg.min_length == '0) || (cnt_x >= min_x)) begin
							d_strm  = 1'b1;
							d_ec    = key_code;
							d_ev    = 1'b1;
							d_count = '0;
							d_scode = '0;
							d_sflag = 1'b0;
							d_prog  = had;
						end
					end else if ((cfg.allowed_mask == '0) || cfg.allowed_mask[key_code]) begin
						// surplus keys beyond the limit are dropped
						if (cnt_x < limit) begin
							d_store = 1'b1;
							d_count = cnt_inc;
							d_slen  = cnt_inc;
						end
						if ((cfg.max_length != '0) && (CMP_W'(d_slen) == limit) &&
						    !END_KEY_REQUIRED) begin
							// auto submit at the length limit
							d_strm  = 1'b1;
							d_count = '0;
							d_scode = '0;
							d_sflag = 1'b0;
						end
						d_prog = 1'b1;
					end
				end
			end
			kec_pkg::FUNC_TICK: begin
				d_idle = (idle_q == '1) ? idle_q : idle_q + 1'b1;
				if ((cfg.timeout_ms != '0) && (count_q != '0) && (d_idle >= cfg.timeout_ms)) begin
					d_strm  = 1'b1;
					d_kind  = kec_pkg::KIND_TIMEOUT;
					d_count = '0;
					d_scode = '0;
					d_sflag = 1'b0;
					d_prog  = 1'b1;
				end
			end
			kec_pkg::FUNC_ENABLE: begin
				d_active = 1'b1;
			end
			default: begin
				// disable: drop the entry silently
				d_active = 1'b0;
				d_count  = '0;
				d_scode  = '0;
				d_sflag  = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	logic              slot_free;
	logic [CW-1:0]     idx_nxt;
	logic              more;
	logic              out_load;
	kec_pkg::kind_t    o_kind;
	logic [KW-1:0]     o_key;
	logic [kec_pkg::POS_W-1:0] o_pos;
	logic [kec_pkg::LEN_W-1:0] o_len;
	logic [KW-1:0]     o_sc;
	logic              o_sv;
	logic [KW-1:0]     o_ec;
	logic              o_ev;
	logic              o_last;

	assign slot_free = !out_valid_q || out_ready;
	assign idx_nxt   = idx_q + 1'b1;
	assign more      = (idx_nxt < strm_len_q);
	assign mem_we    = in_accept && d_store;

	always_comb begin
		out_load = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cnt_m1[AW-1:0];
		o_kind   = kec_pkg::KIND_PROGRESS;
		o_key    = '0;
		o_pos    = '0;
		o_len    = kec_pkg::LEN_W'(count_q);
		o_sc     = start_code_q;
		o_sv     = start_flag_q;
		o_ec     = '0;
		o_ev     = 1'b0;
		o_last   = 1'b1;
		case (state_q)
			S_SRD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			S_SOUT: begin
				out_load = slot_free;
				o_kind   = strm_kind_q;
				o_key    = (strm_len_q == '0) ? '0 : mem_rdata_q;
				o_pos    = kec_pkg::POS_W'(idx_q);
				o_len    = kec_pkg::LEN_W'(strm_len_q);
				o_sc     = strm_sc_q;
				o_sv     = strm_sv_q;
				o_ec     = strm_ec_q;
				o_ev     = strm_ev_q;
				o_last   = !more && !prog_q;
				// read ahead so words leave back to back
				rd_en    = slot_free && (more || prog_q);
				rd_addr  = more ? idx_nxt[AW-1:0] : cnt_m1[AW-1:0];
			end
			S_PRD: begin
				rd_en = 1'b1;
			end
			S_POUT: begin
				out_load = slot_free;
				if (count_q != '0) begin
					o_key = mem_rdata_q;
					o_pos = kec_pkg::POS_W'(cnt_m1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= key_code;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			count_q          <= '0;
			start_code_q     <= '0;
			start_flag_q     <= 1'b0;
			active_q         <= 1'b1;
			idle_q           <= '0;
			idx_q            <= '0;
			strm_len_q       <= '0;
			strm_kind_q      <= kec_pkg::KIND_SUBMIT;
			strm_sc_q        <= '0;
			strm_sv_q        <= 1'b0;
			strm_ec_q        <= '0;
			strm_ev_q        <= 1'b0;
			prog_q           <= 1'b0;
			out_valid_q      <= 1'b0;
			kind_q           <= kec_pkg::KIND_PROGRESS;
			key_value_q      <= '0;
			position_q       <= '0;
			length_q         <= '0;
			start_code_out_q <= '0;
			start_valid_q    <= 1'b0;
			end_code_q       <= '0;
			end_valid_q      <= 1'b0;
			last_q           <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q      <= 1'b1;
				kind_q           <= o_kind;
				key_value_q      <= o_key;
				position_q       <= o_pos;
				length_q         <= o_len;
				start_code_out_q <= o_sc;
				start_valid_q    <= o_sv;
				end_code_q       <= o_ec;
				end_valid_q      <= o_ev;
				last_q           <= o_last;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						count_q      <= d_count;
						start_code_q <= d_scode;
						start_flag_q <= d_sflag;
						active_q     <= d_active;
						idle_q       <= d_idle;
						idx_q        <= '0;
						strm_len_q   <= d_slen;
						strm_kind_q  <= d_kind;
						strm_sc_q    <= start_code_q;
						strm_sv_q    <= start_flag_q;
						strm_ec_q    <= d_ec;
						strm_ev_q    <= d_ev;
						prog_q       <= d_prog;
						if (d_strm) begin
							state_q <= S_SRD;
						end else if (d_prog) begin
							state_q <= S_PRD;
						end
					end
				end
				S_SRD: begin
					state_q <= S_SOUT;
				end
				S_SOUT: begin
					if (slot_free) begin
						if (more) begin
							idx_q <= idx_nxt;
						end else if (prog_q) begin
							state_q <= S_POUT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PRD: begin
					state_q <= S_POUT;
				end
				S_POUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign key_value    = key_value_q;
	assign position     = position_q;
	assign entry_length = length_q;
	assign start_code   = start_code_out_q;
	assign start_valid  = start_valid_q;
	assign end_code     = end_code_q;
	assign end_valid    = end_valid_q;
	assign last         = last_q;

`ifndef SYNTH
	// entry never grows past the memory
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRY_CAPACITY))
		else $error("entry count above capacity");

	// the memory is only written when an input word is taken
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (in_valid && in_ready))
		else $error("entry write outside acceptance");

	// stream index stays inside the streamed entry
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SOUT && strm_len_q != '0) |-> (idx_q < strm_len_q))
		else $error("stream index past entry length");

	// loading the final word of a run returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && o_last) |=> (state_q == S_IDLE))
		else $error("sequencer busy after last word");
`endif

endmodule

// ===== sv/kec_cfg_regs.sv =====
// Configuration register file: index decode and storage of masks and limits.
module kec_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [kec_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [kec_pkg::MASK_W-1:0]       wr_data,
	output kec_pkg::cfg_t                    cfg
);

	kec_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				kec_pkg::CFG_START_MASK:   cfg_q.start_mask   <= wr_data;
				kec_pkg::CFG_BACK_MASK:    cfg_q.back_mask    <= wr_data;
				kec_pkg::CFG_CLEAR_MASK:   cfg_q.clear_mask   <= wr_data;
				kec_pkg::CFG_END_MASK:     cfg_q.end_mask     <= wr_data;
				kec_pkg::CFG_ALLOWED_MASK: cfg_q.allowed_mask <= wr_data;
				kec_pkg::CFG_MIN_LENGTH:   cfg_q.min_length   <= wr_data[kec_pkg::LEN_W-1:0];
				kec_pkg::CFG_MAX_LENGTH:   cfg_q.max_length   <= wr_data[kec_pkg::LEN_W-1:0];
				kec_pkg::CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= wr_data[kec_pkg::TICK_W-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
